// ----- rtl/cascaded_moving_average_iq_defines.svh -----
// Assertion macros shared by the cascaded moving-average I/Q filter.
`ifndef CASCADED_MOVING_AVERAGE_IQ_DEFINES_SVH
`define CASCADED_MOVING_AVERAGE_IQ_DEFINES_SVH

// Check that expr holds in the same cycle whenever cond holds.
`define CMA_ASSERT_IMPLY(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("cma: same-cycle check failed");

// Check that expr holds in the cycle after cond holds.
`define CMA_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("cma: next-cycle check failed");

`endif

// ----- rtl/cma_pkg.sv -----
// Shared constants and types of the cascaded moving-average I/Q filter.
`default_nettype none

package cma_pkg;

    // Parameter defaults
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int MAX_STAGES_DEF  = 4;
    localparam int SAMPLE_BITS_DEF = 16;

    // Register field widths
    localparam int WL_W       = 7;
    localparam int PC_W       = 3;
    localparam int MANT_W     = 16;
    localparam int SHIFT_W    = 6;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Register reset values
    localparam logic [WL_W-1:0]    WL_RESET    = 7'd1;
    localparam logic [PC_W-1:0]    PC_RESET    = 3'd1;
    localparam logic [MANT_W-1:0]  MANT_RESET  = 16'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd0;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH  = 2'd0,
        REG_PASS_COUNT     = 2'd1,
        REG_SCALE_MANTISSA = 2'd2,
        REG_SCALE_SHIFT    = 2'd3
    } cfg_index_t;

    // Control that travels with each word from cell to cell
    typedef struct packed {
        logic valid;   // word present
        logic last;    // word sits at the final delay-line position
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/cma_cell.sv -----
// One boxcar stage: delay line memory and running sums for I and Q.
`default_nettype none

module cma_cell #(
    parameter int MAX_WINDOW = cma_pkg::MAX_WINDOW_DEF,
    parameter int SUM_W      = 40
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          clear,
    input  wire cma_pkg::cell_ctl_t            ctl_in,
    input  wire logic [$clog2(MAX_WINDOW)-1:0] pos_in,
    input  wire logic signed [SUM_W-1:0]       x_i_in,
    input  wire logic signed [SUM_W-1:0]       x_q_in,
    output cma_pkg::cell_ctl_t                 ctl_out,
    output logic [$clog2(MAX_WINDOW)-1:0]      pos_out,
    output logic signed [SUM_W-1:0]            sum_i,
    output logic signed [SUM_W-1:0]            sum_q
);

    localparam int POS_W = $clog2(MAX_WINDOW);

    logic signed [SUM_W-1:0] mem_i [MAX_WINDOW];
    logic signed [SUM_W-1:0] mem_q [MAX_WINDOW];

    logic                    lap_reg;
    cma_pkg::cell_ctl_t      ctl_a_reg;
    logic [POS_W-1:0]        pos_a_reg;
    logic                    lap_a_reg;
    logic signed [SUM_W-1:0] x_i_a_reg;
    logic signed [SUM_W-1:0] x_q_a_reg;
    logic signed [SUM_W-1:0] old_i_reg;
    logic signed [SUM_W-1:0] old_q_reg;

    cma_pkg::cell_ctl_t      ctl_b_reg;
    logic [POS_W-1:0]        pos_b_reg;
    logic signed [SUM_W-1:0] sum_i_reg;
    logic signed [SUM_W-1:0] sum_q_reg;
    logic signed [SUM_W-1:0] sum_i_next;
    logic signed [SUM_W-1:0] sum_q_next;
    logic signed [SUM_W-1:0] old_i_sel;
    logic signed [SUM_W-1:0] old_q_sel;

    // Read the leaving word and store the arriving one at the same position
    always_ff @(posedge clk)
    begin
        if (adv && ctl_in.valid)
        begin
            mem_i[pos_in] <= x_i_in;
            mem_q[pos_in] <= x_q_in;
            old_i_reg     <= mem_i[pos_in];
            old_q_reg     <= mem_q[pos_in];
        end
    end

    // Hold the arriving word beside the memory read
    always_ff @(posedge clk)
    begin
        if (adv && ctl_in.valid)
        begin
            x_i_a_reg <= x_i_in;
            x_q_a_reg <= x_q_in;
            pos_a_reg <= pos_in;
            lap_a_reg <= lap_reg;
        end
    end

    // Track whether the delay line has been filled once since clearing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lap_reg   <= 1'b0;
            ctl_a_reg <= '0;
        end
        else if (clear)
        begin
            lap_reg   <= 1'b0;
            ctl_a_reg <= '0;
        end
        else if (adv)
        begin
            ctl_a_reg <= ctl_in;
            if (ctl_in.valid && ctl_in.last)
            begin
                lap_reg <= 1'b1;
            end
        end
    end

    // Unwritten entries on the first lap read as zero
    always_comb
    begin
        old_i_sel  = lap_a_reg ? old_i_reg : '0;
        old_q_sel  = lap_a_reg ? old_q_reg : '0;
        sum_i_next = sum_i_reg + x_i_a_reg - old_i_sel;
        sum_q_next = sum_q_reg + x_q_a_reg - old_q_sel;
    end

    // Update the running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_i_reg <= '0;
            sum_q_reg <= '0;
            ctl_b_reg <= '0;
        end
        else if (clear)
        begin
            sum_i_reg <= '0;
            sum_q_reg <= '0;
            ctl_b_reg <= '0;
        end
        else if (adv)
        begin
            ctl_b_reg <= ctl_a_reg;
            if (ctl_a_reg.valid)
            begin
                sum_i_reg <= sum_i_next;
                sum_q_reg <= sum_q_next;
            end
        end
    end

    // Pass the position on with the word
    always_ff @(posedge clk)
    begin
        if (adv && ctl_a_reg.valid)
        begin
            pos_b_reg <= pos_a_reg;
        end
    end

    assign ctl_out = ctl_b_reg;
    assign pos_out = pos_b_reg;
    assign sum_i   = sum_i_reg;
    assign sum_q   = sum_q_reg;

endmodule

`default_nettype wire

// ----- rtl/cma_scale.sv -----
// Output scaling: split multiply, rounding shift and saturation for I and Q.
`default_nettype none

module cma_scale #(
    parameter int SUM_W       = 40,
    parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire logic signed [SUM_W-1:0]       sum_i,
    input  wire logic signed [SUM_W-1:0]       sum_q,
    input  wire logic [cma_pkg::MANT_W-1:0]    mantissa,
    input  wire logic [cma_pkg::SHIFT_W-1:0]   shift,
    output logic                               out_valid,
    output logic [SAMPLE_BITS-1:0]             out_i,
    output logic [SAMPLE_BITS-1:0]             out_q,
    output logic                               clipped
);

    localparam int MANT_W = cma_pkg::MANT_W;
    localparam int LO_W   = SUM_W / 2;
    localparam int HI_W   = SUM_W - LO_W;
    localparam int LOP_W  = LO_W + MANT_W;
    localparam int HIP_W  = HI_W + MANT_W + 1;
    localparam int P_W    = SUM_W + MANT_W + 1;

    localparam logic signed [P_W-1:0] SAT_HI = P_W'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [P_W-1:0] SAT_LO = P_W'(-(2 ** (SAMPLE_BITS - 1)));
    localparam logic [SAMPLE_BITS-1:0] RAIL_HI = SAT_HI[SAMPLE_BITS-1:0];
    localparam logic [SAMPLE_BITS-1:0] RAIL_LO = SAT_LO[SAMPLE_BITS-1:0];

    logic signed [SUM_W-1:0] ch_sum [2];

    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;
    logic                    out_valid_reg;
    logic                    zero_sh_reg;
    logic [2:0]              ch_clip;
    logic [SAMPLE_BITS-1:0]  ch_out [2];

    assign ch_sum[0] = sum_i;
    assign ch_sum[1] = sum_q;

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // Hold whether the shift is zero alongside the shifted product
    always_ff @(posedge clk)
    begin
        if (adv && v2_reg)
        begin
            zero_sh_reg <= (shift == '0);
        end
    end

    for (genvar ch = 0; ch < 2; ch++)
    begin : g_ch
        logic [LOP_W-1:0]        lo_reg;
        logic signed [HIP_W-1:0] hi_reg;
        logic [LOP_W-1:0]        lo_next;
        logic signed [HIP_W-1:0] hi_next;
        logic signed [P_W-1:0]   p_reg;
        logic signed [P_W-1:0]   p_next;
        logic signed [P_W-1:0]   q_reg;
        logic signed [P_W-1:0]   q_next;
        logic signed [P_W-1:0]   r;
        logic [SAMPLE_BITS-1:0]  o_reg;
        logic [SAMPLE_BITS-1:0]  o_next;
        logic                    c_reg;
        logic                    c_next;

        // Partial products of the low and high halves of the sum
        always_comb
        begin
            lo_next = LOP_W'(ch_sum[ch][LO_W-1:0]) * LOP_W'(mantissa);
            hi_next = HIP_W'($signed(ch_sum[ch][SUM_W-1:LO_W]))
                      * HIP_W'($signed({1'b0, mantissa}));
            p_next  = (P_W'(hi_reg) <<< LO_W) + P_W'($signed({1'b0, lo_reg}));
            q_next  = (shift == '0) ? p_reg : (p_reg >>> (shift - 1'b1));
        end

        // Round half up: floor shift, then add the bit just below
        always_comb
        begin
            if (zero_sh_reg)
            begin
                r = q_reg;
            end
            else
            begin
                r = (q_reg >>> 1) + $signed({{(P_W-1){1'b0}}, q_reg[0]});
            end
            c_next = 1'b0;
            o_next = r[SAMPLE_BITS-1:0];
            if (r > SAT_HI)
            begin
                o_next = RAIL_HI;
                c_next = 1'b1;
            end
            else if (r < SAT_LO)
            begin
                o_next = RAIL_LO;
                c_next = 1'b1;
            end
        end

        // Multiply, combine, shift and saturate stages
        always_ff @(posedge clk)
        begin
            if (adv && in_valid)
            begin
                lo_reg <= lo_next;
                hi_reg <= hi_next;
            end
            if (adv && v1_reg)
            begin
                p_reg <= p_next;
            end
            if (adv && v2_reg)
            begin
                q_reg <= q_next;
            end
            if (adv && v3_reg)
            begin
                o_reg <= o_next;
                c_reg <= c_next;
            end
        end

        assign ch_out[ch]  = o_reg;
        assign ch_clip[ch] = c_reg;
    end

    assign ch_clip[2] = ch_clip[0] | ch_clip[1];
    assign out_valid  = out_valid_reg;
    assign out_i      = ch_out[0];
    assign out_q      = ch_out[1];
    assign clipped    = ch_clip[2];

endmodule

`default_nettype wire

// ----- rtl/cascaded_moving_average_iq.sv -----
// Top level of the cascaded moving-average I/Q filter.
`default_nettype none
`include "cascaded_moving_average_iq_defines.svh"

// Cascaded moving-average filter for complex I/Q words. Each word passes
// through pass_count boxcar cells of window_length samples each, then is
// multiplied by scale_mantissa, shifted right by scale_shift with round half
// up, and saturated; tuser flags clipping. The block takes one word per
// clock cycle whenever the output is not stalled. The pipeline has one input
// register, two stages per boxcar cell (delay-line memory read, sum update)
// and four scaling stages (split multiply, combine, shift, round/saturate).
// Writing window_length or pass_count clears all sums and the window
// position in that same cycle; stale delay-line entries are masked until
// each cell has completed one full lap, so no clearing pass is needed.
// Configuration is to be written only while no word is in flight.
module cascaded_moving_average_iq #(
    parameter int MAX_WINDOW  = cma_pkg::MAX_WINDOW_DEF,
    parameter int MAX_STAGES  = cma_pkg::MAX_STAGES_DEF,
    parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input words: sample_i, sample_q
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // Output words: out_i, out_q
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        m_axis_tdata,
    // Output flags: clipped
    output logic [0:0]                                m_axis_tuser,
    // Configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [cma_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [cma_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int TDATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int POS_W      = $clog2(MAX_WINDOW);
    localparam int WIN_CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SEL_W      = $clog2(MAX_STAGES + 1);
    localparam int SUM_W      = SAMPLE_BITS + MAX_STAGES * $clog2(MAX_WINDOW);

    localparam logic [SAMPLE_BITS-1:0] RAIL_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] RAIL_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [cma_pkg::WL_W-1:0]    window_length_reg;
    logic [cma_pkg::PC_W-1:0]    pass_count_reg;
    logic [cma_pkg::MANT_W-1:0]  scale_mantissa_reg;
    logic [cma_pkg::SHIFT_W-1:0] scale_shift_reg;

    logic                        clear;
    logic                        adv;
    logic                        accept;
    logic [WIN_CNT_W-1:0]        eff_win;
    logic [SEL_W-1:0]            eff_passes;
    logic [POS_W-1:0]            pos_reg;
    logic [POS_W-1:0]            pos_next;
    logic [WIN_CNT_W-1:0]        pos_inc;
    logic                        pos_last;

    cma_pkg::cell_ctl_t          in_ctl_reg;
    logic [POS_W-1:0]            in_pos_reg;
    logic signed [SUM_W-1:0]     in_i_reg;
    logic signed [SUM_W-1:0]     in_q_reg;

    cma_pkg::cell_ctl_t          tap_ctl [MAX_STAGES+1];
    logic [POS_W-1:0]            tap_pos [MAX_STAGES+1];
    logic signed [SUM_W-1:0]     tap_i   [MAX_STAGES+1];
    logic signed [SUM_W-1:0]     tap_q   [MAX_STAGES+1];

    logic                        out_valid;
    logic [SAMPLE_BITS-1:0]      out_i;
    logic [SAMPLE_BITS-1:0]      out_q;
    logic                        clipped;

    // Decode writes; the length and pass count clear the cells
    always_comb
    begin
        clear = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cma_pkg::cfg_index_t'(cfg_index))
                cma_pkg::REG_WINDOW_LENGTH,
                cma_pkg::REG_PASS_COUNT:     clear = 1'b1;
                cma_pkg::REG_SCALE_MANTISSA,
                cma_pkg::REG_SCALE_SHIFT:    clear = 1'b0;
                default:                     clear = 1'b0;
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg  <= cma_pkg::WL_RESET;
            pass_count_reg     <= cma_pkg::PC_RESET;
            scale_mantissa_reg <= cma_pkg::MANT_RESET;
            scale_shift_reg    <= cma_pkg::SHIFT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cma_pkg::cfg_index_t'(cfg_index))
                cma_pkg::REG_WINDOW_LENGTH:
                    window_length_reg  <= cfg_data[cma_pkg::WL_W-1:0];
                cma_pkg::REG_PASS_COUNT:
                    pass_count_reg     <= cfg_data[cma_pkg::PC_W-1:0];
                cma_pkg::REG_SCALE_MANTISSA:
                    scale_mantissa_reg <= cfg_data[cma_pkg::MANT_W-1:0];
                cma_pkg::REG_SCALE_SHIFT:
                    scale_shift_reg    <= cfg_data[cma_pkg::SHIFT_W-1:0];
                default:
                    scale_shift_reg    <= scale_shift_reg;
            endcase
        end
    end

    // Clamp the window and pass count to what the hardware holds
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            eff_win = WIN_CNT_W'(1);
        end
        else if (int'(window_length_reg) > MAX_WINDOW)
        begin
            eff_win = WIN_CNT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_win = WIN_CNT_W'(window_length_reg);
        end

        if (int'(pass_count_reg) > MAX_STAGES)
        begin
            eff_passes = SEL_W'(MAX_STAGES);
        end
        else
        begin
            eff_passes = SEL_W'(pass_count_reg);
        end
    end

    // The whole chain moves whenever the output register can take a word
    assign adv           = !out_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // Step the shared window position, wrapping at the window length
    always_comb
    begin
        pos_inc  = WIN_CNT_W'(pos_reg) + WIN_CNT_W'(1);
        pos_last = (pos_inc == eff_win);
        pos_next = pos_last ? '0 : pos_inc[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            in_ctl_reg <= '0;
        end
        else if (clear)
        begin
            pos_reg    <= '0;
            in_ctl_reg <= '0;
        end
        else if (adv)
        begin
            in_ctl_reg.valid <= s_axis_tvalid;
            in_ctl_reg.last  <= pos_last;
            if (s_axis_tvalid)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    // Capture the input word, sign-extended to the sum width
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_pos_reg <= pos_reg;
            in_i_reg   <= SUM_W'($signed(s_axis_tdata[SAMPLE_BITS-1:0]));
            in_q_reg   <= SUM_W'($signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
        end
    end

    assign tap_ctl[0] = in_ctl_reg;
    assign tap_pos[0] = in_pos_reg;
    assign tap_i[0]   = in_i_reg;
    assign tap_q[0]   = in_q_reg;

    // Chain of boxcar cells
    for (genvar k = 0; k < MAX_STAGES; k++)
    begin : g_cell
        cma_cell #(
            .MAX_WINDOW (MAX_WINDOW),
            .SUM_W      (SUM_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .clear   (clear),
            .ctl_in  (tap_ctl[k]),
            .pos_in  (tap_pos[k]),
            .x_i_in  (tap_i[k]),
            .x_q_in  (tap_q[k]),
            .ctl_out (tap_ctl[k+1]),
            .pos_out (tap_pos[k+1]),
            .sum_i   (tap_i[k+1]),
            .sum_q   (tap_q[k+1])
        );
    end

    // Take the word from the last cell in use and scale it
    cma_scale #(
        .SUM_W       (SUM_W),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (tap_ctl[eff_passes].valid),
        .sum_i     (tap_i[eff_passes]),
        .sum_q     (tap_q[eff_passes]),
        .mantissa  (scale_mantissa_reg),
        .shift     (scale_shift_reg),
        .out_valid (out_valid),
        .out_i     (out_i),
        .out_q     (out_q),
        .clipped   (clipped)
    );

    assign m_axis_tvalid   = out_valid;
    assign m_axis_tdata    = TDATA_W'({out_q, out_i});
    assign m_axis_tuser[0] = clipped;

    // Checks
    `CMA_ASSERT_IMPLY(a_pos_in_window, 1'b1, pos_reg < eff_win)
    `CMA_ASSERT_NEXT(a_clear_restarts, clear, pos_reg == '0 && !in_ctl_reg.valid)
    `CMA_ASSERT_NEXT(a_accept_loads, accept && !clear, in_ctl_reg.valid && in_pos_reg == $past(pos_reg))
    `CMA_ASSERT_IMPLY(a_clip_at_rail, m_axis_tvalid && m_axis_tuser[0], out_i == RAIL_HI || out_i == RAIL_LO || out_q == RAIL_HI || out_q == RAIL_LO)

endmodule

`default_nettype wire

// ----- tb/cascaded_moving_average_iq_tb.sv -----
// Self-checking testbench for the cascaded moving-average I/Q filter.
`default_nettype none

module cascaded_moving_average_iq_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_STAGES   = cma_pkg::MAX_STAGES_DEF;
    localparam int WINDOW_DEPTH = cma_pkg::MAX_WINDOW_DEF;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_WORDS = 450;

    typedef struct packed {
        logic signed [15:0] i;
        logic signed [15:0] q;
        logic               clip;
    } iq_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [31:0]                    s_axis_tdata = '0;   // sample_i [15:0], sample_q [31:16]
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [31:0]                    m_axis_tdata;        // out_i [15:0], out_q [31:16]
    logic [0:0]                     m_axis_tuser;        // clipped [0]
    logic                           cfg_wr_en = 1'b0;
    cma_pkg::cfg_index_t            cfg_index = cma_pkg::REG_WINDOW_LENGTH;
    logic [cma_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Filter state as predicted from the register writes and accepted words
    logic [cma_pkg::WL_W-1:0]    win_reg   = cma_pkg::WL_RESET;
    logic [cma_pkg::PC_W-1:0]    pass_reg  = cma_pkg::PC_RESET;
    logic [cma_pkg::MANT_W-1:0]  mant_reg  = cma_pkg::MANT_RESET;
    logic [cma_pkg::SHIFT_W-1:0] shift_reg = cma_pkg::SHIFT_RESET;
    longint             hist_i [NUM_STAGES][WINDOW_DEPTH];
    longint             hist_q [NUM_STAGES][WINDOW_DEPTH];
    longint             sum_i [NUM_STAGES];
    longint             sum_q [NUM_STAGES];
    int                 win_pos;

    logic [31:0] sample_queue [$];
    iq_result_t  expected_iq [$];
    int          words_queued = 0;
    int          words_taken = 0;
    int          fail_count = 0;
    int          idle_pct = 10;
    bit          in_taken = 1'b0;
    bit          hold_request = 1'b0;
    int          hold_left = 0;

    cascaded_moving_average_iq i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int eff_window();
        if (win_reg == 0)
            return 1;
        if (win_reg > WINDOW_DEPTH)
            return WINDOW_DEPTH;
        return int'(win_reg);
    endfunction

    function automatic int eff_passes();
        return (pass_reg > NUM_STAGES) ? NUM_STAGES : int'(pass_reg);
    endfunction

    task automatic clear_history();
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            sum_i[s] = 0;
            sum_q[s] = 0;
            for (int k = 0; k < WINDOW_DEPTH; k++)
            begin
                hist_i[s][k] = 0;
                hist_q[s][k] = 0;
            end
        end
        win_pos = 0;
    endtask

    // Multiply, round half up, saturate; bit 16 flags clipping
    function automatic logic [16:0] scale_sample(longint v);
        longint prod;
        longint r;
        logic   clip;
        clip = 1'b0;
        prod = v * longint'(mant_reg);
        if (shift_reg != 0)
            prod += longint'(1) << (shift_reg - 1);
        r = prod >>> shift_reg;
        if (r > 32767)
        begin
            r = 32767;
            clip = 1'b1;
        end
        else if (r < -32768)
        begin
            r = -32768;
            clip = 1'b1;
        end
        return {clip, r[15:0]};
    endfunction

    // Run one I/Q word through the boxcar cascade and the output scaling
    function automatic iq_result_t filter_word(logic signed [15:0] xi, logic signed [15:0] xq);
        int          win;
        int          passes;
        int          pos;
        longint      acc_i;
        longint      acc_q;
        logic [16:0] ri;
        logic [16:0] rq;
        iq_result_t  res;
        win = eff_window();
        passes = eff_passes();
        pos = (win_pos >= win) ? 0 : win_pos;
        acc_i = xi;
        acc_q = xq;
        for (int s = 0; s < passes; s++)
        begin
            sum_i[s] = sum_i[s] + acc_i - hist_i[s][pos];
            hist_i[s][pos] = acc_i;
            acc_i = sum_i[s];
            sum_q[s] = sum_q[s] + acc_q - hist_q[s][pos];
            hist_q[s][pos] = acc_q;
            acc_q = sum_q[s];
        end
        pos++;
        win_pos = (pos >= win) ? 0 : pos;
        ri = scale_sample(acc_i);
        rq = scale_sample(acc_q);
        res.i = ri[15:0];
        res.q = rq[15:0];
        res.clip = ri[16] | rq[16];
        return res;
    endfunction

    // Write one register while the block is idle and mirror it in the prediction
    task automatic write_reg(cma_pkg::cfg_index_t idx, logic [cma_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            cma_pkg::REG_WINDOW_LENGTH:
            begin
                win_reg = val[cma_pkg::WL_W-1:0];
                clear_history();
            end
            cma_pkg::REG_PASS_COUNT:
            begin
                pass_reg = val[cma_pkg::PC_W-1:0];
                clear_history();
            end
            cma_pkg::REG_SCALE_MANTISSA: mant_reg = val[cma_pkg::MANT_W-1:0];
            cma_pkg::REG_SCALE_SHIFT:    shift_reg = val[cma_pkg::SHIFT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_word(logic [15:0] si, logic [15:0] sq);
        sample_queue.push_back({sq, si});
        words_queued++;
    endtask

    // Hold until every queued word is taken and answered, then let the pipe settle
    task automatic wait_idle();
        while (words_taken != words_queued || expected_iq.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Sender: offer the next queued word, idling now and then
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (sample_queue.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                s_axis_tdata  <= sample_queue.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Predict on each accepted input word, check each accepted output word
    always @(posedge clk)
    begin
        iq_result_t want;
        in_taken = s_axis_tvalid && s_axis_tready;
        if (rst_n && in_taken)
        begin
            expected_iq.push_back(filter_word(s_axis_tdata[15:0], s_axis_tdata[31:16]));
            words_taken++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_iq.size() == 0)
            begin
                $error("unexpected output word: out_i %0d out_q %0d clipped %0d",
                       $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                       m_axis_tuser[0]);
                fail_count++;
            end
            else
            begin
                want = expected_iq.pop_front();
                if (m_axis_tdata[15:0] !== want.i)
                begin
                    $error("out_i: expected %0d, got %0d", want.i,
                           $signed(m_axis_tdata[15:0]));
                    fail_count++;
                end
                if (m_axis_tdata[31:16] !== want.q)
                begin
                    $error("out_q: expected %0d, got %0d", want.q,
                           $signed(m_axis_tdata[31:16]));
                    fail_count++;
                end
                if (m_axis_tuser[0] !== want.clip)
                begin
                    $error("clipped: expected %0d, got %0d", want.clip, m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus: directed settings first, then random configurations and words
    initial
    begin
        int                             rand_words;
        int                             phase;
        int                             n_words;
        int                             style;
        int                             kind;
        int                             sh;
        longint unsigned                den;
        longint unsigned                mant;
        logic [cma_pkg::CFG_DATA_W-1:0] data;
        logic [15:0]                    lvl_i;
        logic [15:0]                    lvl_q;
        logic [15:0]                    vi;
        logic [15:0]                    vq;

        clear_history();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: single window, one pass, unit scale
        push_word(16'h0000, 16'h0000);
        push_word(16'h7FFF, 16'h8000);
        push_word(16'h8000, 16'h7FFF);
        push_word(16'h0001, 16'hFFFF);
        wait_idle();

        // Zero window, bypass, full mantissa: everything but zero clips
        write_reg(cma_pkg::REG_WINDOW_LENGTH, 16'h0000);
        write_reg(cma_pkg::REG_PASS_COUNT, 16'h0000);
        write_reg(cma_pkg::REG_SCALE_MANTISSA, 16'hFFFF);
        write_reg(cma_pkg::REG_SCALE_SHIFT, 16'h0000);
        push_word(16'h0001, 16'hFFFF);
        push_word(16'h0000, 16'h0000);
        push_word(16'h8000, 16'h7FFF);
        push_word(16'h5555, 16'hAAAA);
        wait_idle();

        // Halving with round half up on odd values of both signs
        write_reg(cma_pkg::REG_SCALE_MANTISSA, 16'h0001);
        write_reg(cma_pkg::REG_SCALE_SHIFT, 16'hFFC1);
        push_word(16'h0001, 16'hFFFF);
        push_word(16'h0003, 16'hFFFD);
        push_word(16'h7FFF, 16'h8000);
        push_word(16'hFFFE, 16'h0002);
        wait_idle();

        // Oversized window and pass count with upper data bits set, unit scale
        write_reg(cma_pkg::REG_WINDOW_LENGTH, 16'hFFFF);
        write_reg(cma_pkg::REG_PASS_COUNT, 16'hFFFF);
        write_reg(cma_pkg::REG_SCALE_SHIFT, 16'h0000);
        repeat (4) push_word(16'h7FFF, 16'h8000);
        wait_idle();

        // Scale writes keep the running sums; shift by the largest amount
        write_reg(cma_pkg::REG_SCALE_MANTISSA, 16'hFFFF);
        write_reg(cma_pkg::REG_SCALE_SHIFT, 16'h003F);
        push_word(16'h8000, 16'h7FFF);
        push_word(16'h8000, 16'h7FFF);
        wait_idle();
        write_reg(cma_pkg::REG_SCALE_MANTISSA, 16'h8000);
        write_reg(cma_pkg::REG_SCALE_SHIFT, 16'h0027);
        push_word(16'h1234, 16'hEDCB);
        push_word(16'h8000, 16'h7FFF);
        wait_idle();

        // Random phases
        rand_words = 0;
        phase = 0;
        while (rand_words < RANDOM_WORDS)
        begin
            if (phase == 0 || $urandom_range(9) < 7)
            begin
                kind = $urandom_range(9);
                data = 16'($urandom);
                data[cma_pkg::WL_W-1:0] = (kind == 0) ? 7'd1 :
                                          (kind == 1) ? 7'd64 :
                                          (kind == 2) ? 7'd0 :
                                          (kind == 3) ? 7'($urandom_range(65, 127)) :
                                          (kind < 6)  ? 7'($urandom_range(2, 8)) :
                                                        7'($urandom_range(1, 64));
                write_reg(cma_pkg::REG_WINDOW_LENGTH, data);
                kind = $urandom_range(9);
                data = 16'($urandom);
                data[cma_pkg::PC_W-1:0] = (kind < 7) ? 3'($urandom_range(0, 4)) :
                                                       3'($urandom);
                write_reg(cma_pkg::REG_PASS_COUNT, data);
            end

            // Unity gain scale for the current window and pass count
            den = 1;
            for (int k = 0; k < eff_passes(); k++)
                den *= longint'(eff_window());
            sh = 0;
            while ((64'd1 << sh) < den * 32768)
                sh++;
            mant = ((64'd1 << sh) + den / 2) / den;
            if (mant > 65535)
                mant = 65535;
            kind = $urandom_range(9);
            if (kind >= 6 && kind < 8)
            begin
                // Gain above unity so that strong inputs clip
                sh = sh - $urandom_range(1, 4);
            end
            else if (kind == 8)
            begin
                mant = $urandom_range(65535);
                sh = $urandom_range(63);
            end
            else if (kind == 9)
            begin
                mant = $urandom_range(1) ? 65535 : $urandom_range(1);
                sh = $urandom_range(1) ? 63 : 0;
            end
            data = 16'($urandom);
            data[cma_pkg::MANT_W-1:0] = 16'(mant);
            write_reg(cma_pkg::REG_SCALE_MANTISSA, data);
            data = 16'($urandom);
            data[cma_pkg::SHIFT_W-1:0] = 6'(sh);
            write_reg(cma_pkg::REG_SCALE_SHIFT, data);

            n_words = $urandom_range(20, 50);
            if (phase == 3)
            begin
                idle_pct = 0;
                n_words = 100;
            end
            if (phase == 5)
            begin
                hold_request = 1'b1;
                n_words = 120;
            end

            style = $urandom_range(3);
            lvl_i = 16'($urandom);
            lvl_q = 16'($urandom);
            for (int n = 0; n < n_words; n++)
            begin
                case (style)
                    0, 1:
                    begin
                        vi = 16'($urandom);
                        vq = 16'($urandom);
                        if ($urandom_range(15) == 0)
                            vi = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                        if ($urandom_range(15) == 0)
                            vq = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                    end
                    2:
                    begin
                        // Held levels with occasional jumps, often at full scale
                        if ($urandom_range(11) == 0)
                        begin
                            lvl_i = $urandom_range(1) ? 16'($urandom) : 16'h8000;
                            lvl_q = $urandom_range(1) ? 16'($urandom) : 16'h7FFF;
                        end
                        vi = lvl_i;
                        vq = lvl_q;
                    end
                    default:
                    begin
                        vi = 16'($signed($urandom_range(16)) - 8);
                        vq = 16'($signed($urandom_range(16)) - 8);
                    end
                endcase
                push_word(vi, vq);
            end
            rand_words += n_words;
            wait_idle();
            idle_pct = 10;
            phase++;
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/cma_pkg.sv
rtl/cma_cell.sv
rtl/cma_scale.sv
rtl/cascaded_moving_average_iq.sv
tb/cascaded_moving_average_iq_tb.sv
